@@ rtl/opla_pkg.sv @@
// Package for the PLA segmenter: shared constants, register indexes and FSM states.
// No dependencies; used by the interfaces, the top level, the checker and the testbench.
`timescale 1ns / 1ps
package opla_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int LEN_W      = 14;
   localparam int EB_W       = 31;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_ADDR_W = 1;

   localparam int DEF_HULL_DEPTH = 8192;
   localparam int DEF_VALUE_BITS = 32;

   localparam logic [EB_W-1:0]  ERR_BOUND_RESET = 31'd65536;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET   = 14'd8000;
   localparam int               MIN_SEG_LEN     = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_ERROR_BOUND = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_LEN     = 1'd1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_START,
      S_RD1,
      S_RD1W,
      S_CHK,
      S_CHKC,
      S_DECIDE,
      S_FRD0,
      S_FRD0W,
      S_FIT_RD,
      S_FIT_MUL,
      S_FIT_CMP,
      S_FIT_END,
      S_PUSH,
      S_FLUSHCHK,
      S_EM_BEGIN,
      S_EM_OP,
      S_EM_MUL,
      S_EM_ICPT,
      S_EM_WAIT,
      S_EM_OUT
   } state_type;

endpackage

@@ rtl/opla_if.sv @@
// Request and response channel interfaces of the PLA segmenter.
// Depends on opla_pkg for the field widths.
`timescale 1ns / 1ps
interface opla_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [opla_pkg::SAMPLE_W-1:0] sample_value;
   logic                                end_of_stream;

   modport source (output valid, output sample_value, output end_of_stream, input ready);
   modport sink   (input valid, input sample_value, input end_of_stream, output ready);
endinterface

interface opla_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [opla_pkg::LEN_W-1:0]          segment_length;
   logic signed [opla_pkg::SAMPLE_W-1:0] segment_slope;
   logic signed [opla_pkg::SAMPLE_W-1:0] segment_intercept;
   logic                                last_in_run;

   modport source (output valid, output segment_length, output segment_slope,
                   output segment_intercept, output last_in_run, input ready);
   modport sink   (input valid, input segment_length, input segment_slope,
                   input segment_intercept, input last_in_run, output ready);
endinterface

@@ rtl/opla_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module opla_ram #(
   parameter int WIDTH = 46,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/opla_fdiv.sv @@
// Serial signed-by-unsigned divider, one quotient bit per cycle, floor rounding.
// A zero divisor yields zero. No dependencies.
`timescale 1ns / 1ps
module opla_fdiv #(
   parameter int NW = 49,
   parameter int DW = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic signed [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]        mag_ff;
   logic [DW-1:0]        rem_ff;
   logic [DW-1:0]        den_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 neg_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic signed [NW-1:0] quo_ff;

   logic [DW:0]   rem_sh;
   logic          fits;
   logic [DW-1:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, mag_ff[NW-1]};
      fits   = rem_sh >= {1'b0, den_ff};
      rem_in = fits ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            neg_ff <= num[NW-1];
            den_ff <= den;
            rem_ff <= '0;
            if (den == '0) begin
               mag_ff <= '0;
               cnt_ff <= '0;
            end else begin
               mag_ff <= num[NW-1] ? (~num + NW'(1)) : num;
               cnt_ff <= CW'(NW);
            end
         end else if (run_ff) begin
            if (cnt_ff == '0) begin
               // fold the sign back in, stepping down on a nonzero remainder
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
               if (!neg_ff) begin
                  quo_ff <= mag_ff;
               end else if (rem_ff != '0) begin
                  quo_ff <= ~mag_ff;
               end else begin
                  quo_ff <= ~mag_ff + NW'(1);
               end
            end else begin
               mag_ff <= {mag_ff[NW-2:0], fits};
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff - CW'(1);
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

@@ rtl/optimal_pla_segmenter_core.sv @@
// Streaming error-bounded piecewise linear segmenter, top level.
// Depends on opla_pkg, opla_if, opla_ram and opla_fdiv.
`timescale 1ns / 1ps
// One sample is taken at a time. When a bounding line moves, the hull searches
// walk the two hull RAMs one read per entry. Emitting a segment of two or more
// samples runs four divisions through one serial divider. A finished segment waits
// in an output register while the next sample is taken.
module optimal_pla_segmenter_core #(
   parameter int HULL_DEPTH = opla_pkg::DEF_HULL_DEPTH,
   parameter int VALUE_BITS = opla_pkg::DEF_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   opla_req_if.sink                            req_if,
   opla_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [opla_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [opla_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import opla_pkg::*;

   localparam int AW   = $clog2(HULL_DEPTH);
   localparam int XW   = $clog2(HULL_DEPTH + 1);
   localparam int VB   = VALUE_BITS;
   localparam int DVW  = VB + 1;
   localparam int XDW  = XW + 1;
   localparam int PW   = DVW + XDW;
   localparam int NW   = PW + 1;
   localparam int SUMW = NW + 1;
   localparam int OW   = SUMW + 33;
   localparam int EW   = ((VB > 33) ? VB : 33) + 1;
   localparam int MEMW = XW + VB;

   localparam logic signed [EW-1:0] VMAX = EW'((64'sd1 <<< (VB - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);
   localparam logic signed [OW-1:0] OUT_MAX = OW'(33'sh07FFFFFFF);
   localparam logic signed [OW-1:0] OUT_MIN = OW'(33'sh180000000);

   state_type state_ff, state_in;

   logic [EB_W-1:0]            eb_ff;
   logic [LEN_W-1:0]           mlen_ff;
   logic signed [SAMPLE_W-1:0] y_ff;
   logic signed [VB-1:0]       wu_ff, wl_ff;
   logic                       flush_ff;
   logic                       brk_ff;
   logic [XW-1:0]              pts_ff;
   logic signed [SAMPLE_W-1:0] pivot_ff;

   logic [XW-1:0]        start_ff [2];
   logic [XW-1:0]        count_ff [2];
   logic [XW-1:0]        lx0_ff [2];
   logic [XW-1:0]        lx1_ff [2];
   logic signed [VB-1:0] lv0_ff [2];
   logic signed [VB-1:0] lv1_ff [2];

   logic [1:0]           chk_k_ff;
   logic [3:0]           flags_ff;
   logic                 fit_h_ff;
   logic [XW-1:0]        best_ff, i_ff;
   logic [XW-1:0]        bx_ff, xi_ff;
   logic signed [VB-1:0] bv_ff, vi_ff;
   logic [1:0]           em_k_ff;
   logic signed [SUMW-1:0] ssum_ff, isum_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;

   logic                       rsp_valid_ff;
   logic [LEN_W-1:0]           rsp_len_ff;
   logic signed [SAMPLE_W-1:0] rsp_slope_ff, rsp_icpt_ff;
   logic                       rsp_last_ff;

   // accept-time offsets
   logic signed [EW-1:0] sum_u, sum_l;
   logic signed [VB-1:0] wu_new, wl_new;

   always_comb begin
      sum_u  = EW'(req_if.sample_value) + $signed(EW'(eb_ff));
      sum_l  = EW'(req_if.sample_value) - $signed(EW'(eb_ff));
      wu_new = (sum_u > VMAX) ? VB'(VMAX) : ((sum_u < VMIN) ? VB'(VMIN) : VB'(sum_u));
      wl_new = (sum_l > VMAX) ? VB'(VMAX) : ((sum_l < VMIN) ? VB'(VMIN) : VB'(sum_l));
   end

   // hull RAMs: index 0 holds sample-minus-error points, index 1 sample-plus-error
   logic            ram_we [2];
   logic [AW-1:0]   ram_waddr [2];
   logic [MEMW-1:0] ram_wdata [2];
   logic [AW-1:0]   ram_raddr [2];
   logic [MEMW-1:0] ram_rdata [2];
   logic [XW-1:0]   rd_off;
   logic [XW:0]     pos [2];

   opla_ram #(.WIDTH(MEMW), .DEPTH(HULL_DEPTH)) u_ram_upper (
      .clock(clock), .we(ram_we[0]), .waddr(ram_waddr[0]), .wdata(ram_wdata[0]),
      .raddr(ram_raddr[0]), .rdata(ram_rdata[0]));

   opla_ram #(.WIDTH(MEMW), .DEPTH(HULL_DEPTH)) u_ram_lower (
      .clock(clock), .we(ram_we[1]), .waddr(ram_waddr[1]), .wdata(ram_wdata[1]),
      .raddr(ram_raddr[1]), .rdata(ram_rdata[1]));

   // divider
   logic                 div_start, div_done;
   logic signed [NW-1:0] div_num, div_quo;
   logic [XW-1:0]        div_den;

   opla_fdiv #(.NW(NW), .DW(XW)) u_fdiv (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quo(div_quo));

   // shared multiplier pair operands
   logic signed [DVW-1:0] m_a1, m_a2;
   logic signed [XDW-1:0] m_b1, m_b2;
   logic                  cl, el;
   logic signed [VB-1:0]  cw, fw;
   logic [XW-1:0]         rx;
   logic signed [VB-1:0]  rv;
   logic signed [XDW-1:0] xcur;
   logic [31:0]           m_eff, pts32;
   logic                  brk_now, out_free, better, chk_hit;
   logic signed [SUMW-1:0] half_s, half_i;
   logic signed [OW-1:0]   ext_s, ext_i;
   logic signed [SAMPLE_W-1:0] sat_s, sat_i;
   logic [XW+15:0]         len_ext;

   always_comb begin
      cl   = (chk_k_ff == 2'd0) || (chk_k_ff == 2'd3);
      cw   = ((chk_k_ff == 2'd0) || (chk_k_ff == 2'd2)) ? wu_ff : wl_ff;
      fw   = fit_h_ff ? wl_ff : wu_ff;
      el   = em_k_ff[1];
      rx   = ram_rdata[fit_h_ff][MEMW-1:VB];
      rv   = ram_rdata[fit_h_ff][VB-1:0];
      xcur = $signed({1'b0, pts_ff});
      m_a1 = '0;
      m_b1 = '0;
      m_a2 = '0;
      m_b2 = '0;
      case (state_ff)
         S_CHK: begin
            m_a1 = DVW'(lv1_ff[cl]) - DVW'(lv0_ff[cl]);
            m_b1 = xcur - $signed({1'b0, lx0_ff[cl]});
            m_a2 = DVW'(cw) - DVW'(lv0_ff[cl]);
            m_b2 = $signed({1'b0, lx1_ff[cl]}) - $signed({1'b0, lx0_ff[cl]});
         end
         S_FIT_MUL: begin
            m_a1 = DVW'(fw) - DVW'(rv);
            m_b1 = xcur - $signed({1'b0, bx_ff});
            m_a2 = DVW'(fw) - DVW'(bv_ff);
            m_b2 = xcur - $signed({1'b0, rx});
         end
         S_EM_MUL: begin
            m_a1 = DVW'(lv0_ff[el]);
            m_b1 = $signed({1'b0, lx1_ff[el]}) - $signed({1'b0, lx0_ff[el]});
            m_a2 = DVW'(lv1_ff[el]) - DVW'(lv0_ff[el]);
            m_b2 = $signed({1'b0, lx0_ff[el]});
         end
         default: begin
         end
      endcase

      pts32 = 32'(pts_ff);
      if (mlen_ff < LEN_W'(MIN_SEG_LEN)) begin
         m_eff = 32'(MIN_SEG_LEN);
      end else if (32'(mlen_ff) > 32'(HULL_DEPTH)) begin
         m_eff = 32'(HULL_DEPTH);
      end else begin
         m_eff = 32'(mlen_ff);
      end
      brk_now  = flags_ff[0] || flags_ff[1] || (pts32 >= m_eff);
      out_free = !rsp_valid_ff || rsp_if.ready;
      better   = fit_h_ff ? (p1_ff > p2_ff) : (p1_ff < p2_ff);
      chk_hit  = chk_k_ff[0] ? (p1_ff < p2_ff) : (p1_ff > p2_ff);

      half_s = ssum_ff >>> 1;
      half_i = isum_ff >>> 1;
      ext_s  = OW'(half_s);
      ext_i  = OW'(half_i);
      sat_s  = (ext_s > OUT_MAX) ? SAMPLE_W'(OUT_MAX) :
               ((ext_s < OUT_MIN) ? SAMPLE_W'(OUT_MIN) : SAMPLE_W'(ext_s));
      sat_i  = (ext_i > OUT_MAX) ? SAMPLE_W'(OUT_MAX) :
               ((ext_i < OUT_MIN) ? SAMPLE_W'(OUT_MIN) : SAMPLE_W'(ext_i));
      len_ext = (XW + 16)'(pts_ff);
   end

   // memory ports and divider feed
   always_comb begin
      rd_off = '0;
      if (state_ff == S_FIT_RD) begin
         rd_off = i_ff;
      end
      for (int h = 0; h < 2; h++) begin
         pos[h]       = (XW + 1)'(start_ff[h]) + (XW + 1)'(count_ff[h]);
         ram_raddr[h] = AW'(start_ff[h] + rd_off);
         ram_we[h]    = 1'b0;
         ram_waddr[h] = AW'(pos[h]);
         ram_wdata[h] = '0;
      end
      case (state_ff)
         S_START: begin
            ram_we[0]    = 1'b1;
            ram_we[1]    = 1'b1;
            ram_waddr[0] = '0;
            ram_waddr[1] = '0;
            ram_wdata[0] = {XW'(0), wl_ff};
            ram_wdata[1] = {XW'(0), wu_ff};
         end
         S_RD1W: begin
            ram_we[0]    = pos[0] < (XW + 1)'(HULL_DEPTH);
            ram_we[1]    = pos[1] < (XW + 1)'(HULL_DEPTH);
            ram_wdata[0] = {pts_ff, wl_ff};
            ram_wdata[1] = {pts_ff, wu_ff};
         end
         S_PUSH: begin
            ram_we[0]    = flags_ff[3] && (pos[0] < (XW + 1)'(HULL_DEPTH));
            ram_we[1]    = flags_ff[2] && (pos[1] < (XW + 1)'(HULL_DEPTH));
            ram_wdata[0] = {pts_ff, wl_ff};
            ram_wdata[1] = {pts_ff, wu_ff};
         end
         default: begin
         end
      endcase

      div_start = (state_ff == S_EM_ICPT) || ((state_ff == S_EM_OP) && !em_k_ff[0]);
      div_den   = lx1_ff[el] - lx0_ff[el];
      if (state_ff == S_EM_ICPT) begin
         div_num = NW'(p1_ff) - NW'(p2_ff);
      end else begin
         div_num = NW'(DVW'(lv1_ff[el]) - DVW'(lv0_ff[el]));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_if.valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (pts_ff == '0) begin
               state_in = S_START;
            end else if (pts_ff == XW'(1)) begin
               state_in = S_RD1;
            end else begin
               state_in = S_CHK;
            end
         end
         S_START:    state_in = S_FLUSHCHK;
         S_RD1:      state_in = S_RD1W;
         S_RD1W:     state_in = S_FLUSHCHK;
         S_CHK:      state_in = S_CHKC;
         S_CHKC:     state_in = (chk_k_ff == 2'd3) ? S_DECIDE : S_CHK;
         S_DECIDE: begin
            if (brk_now) begin
               state_in = S_EM_BEGIN;
            end else if (flags_ff[2] || flags_ff[3]) begin
               state_in = S_FRD0;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_FRD0:     state_in = S_FRD0W;
         S_FRD0W:    state_in = S_FIT_RD;
         S_FIT_RD:   state_in = (i_ff >= count_ff[fit_h_ff]) ? S_FIT_END : S_FIT_MUL;
         S_FIT_MUL:  state_in = S_FIT_CMP;
         S_FIT_CMP:  state_in = S_FIT_RD;
         S_FIT_END:  state_in = (!fit_h_ff && flags_ff[3]) ? S_FRD0 : S_PUSH;
         S_PUSH:     state_in = S_FLUSHCHK;
         S_FLUSHCHK: state_in = flush_ff ? S_EM_BEGIN : S_IDLE;
         S_EM_BEGIN: state_in = (pts_ff < XW'(2)) ? S_EM_OUT : S_EM_OP;
         S_EM_OP:    state_in = em_k_ff[0] ? S_EM_MUL : S_EM_WAIT;
         S_EM_MUL:   state_in = S_EM_ICPT;
         S_EM_ICPT:  state_in = S_EM_WAIT;
         S_EM_WAIT: begin
            if (div_done) begin
               state_in = (em_k_ff == 2'd3) ? S_EM_OUT : S_EM_OP;
            end
         end
         S_EM_OUT: begin
            if (out_free) begin
               state_in = brk_ff ? S_START : S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         eb_ff   <= ERR_BOUND_RESET;
         mlen_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ERROR_BOUND: eb_ff   <= csr_wdata[EB_W-1:0];
            CSR_MAX_LEN:     mlen_ff <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= m_a1 * m_b1;
      p2_ff <= m_a2 * m_b2;
   end

   // segment state and scan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff      <= '0;
         pivot_ff    <= '0;
         start_ff[0] <= '0;
         start_ff[1] <= '0;
         count_ff[0] <= '0;
         count_ff[1] <= '0;
         brk_ff      <= 1'b0;
         for (int h = 0; h < 2; h++) begin
            lx0_ff[h] <= '0;
            lx1_ff[h] <= '0;
            lv0_ff[h] <= '0;
            lv1_ff[h] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  y_ff     <= req_if.sample_value;
                  flush_ff <= req_if.end_of_stream;
                  wu_ff    <= wu_new;
                  wl_ff    <= wl_new;
                  chk_k_ff <= 2'd0;
               end
            end
            S_START: begin
               pivot_ff    <= y_ff;
               pts_ff      <= XW'(1);
               start_ff[0] <= '0;
               start_ff[1] <= '0;
               count_ff[0] <= XW'(1);
               count_ff[1] <= XW'(1);
               for (int h = 0; h < 2; h++) begin
                  lx0_ff[h] <= '0;
                  lx1_ff[h] <= '0;
                  lv0_ff[h] <= '0;
                  lv1_ff[h] <= '0;
               end
            end
            S_RD1W: begin
               lx0_ff[0] <= ram_rdata[0][MEMW-1:VB];
               lv0_ff[0] <= ram_rdata[0][VB-1:0];
               lx1_ff[0] <= pts_ff;
               lv1_ff[0] <= wu_ff;
               lx0_ff[1] <= ram_rdata[1][MEMW-1:VB];
               lv0_ff[1] <= ram_rdata[1][VB-1:0];
               lx1_ff[1] <= pts_ff;
               lv1_ff[1] <= wl_ff;
               if (pos[0] < (XW + 1)'(HULL_DEPTH)) count_ff[0] <= count_ff[0] + XW'(1);
               if (pos[1] < (XW + 1)'(HULL_DEPTH)) count_ff[1] <= count_ff[1] + XW'(1);
               pts_ff <= XW'(2);
            end
            S_CHKC: begin
               flags_ff[chk_k_ff] <= chk_hit;
               chk_k_ff           <= chk_k_ff + 2'd1;
            end
            S_DECIDE: begin
               brk_ff   <= brk_now;
               fit_h_ff <= !flags_ff[2];
            end
            S_FRD0W: begin
               bx_ff   <= rx;
               bv_ff   <= rv;
               best_ff <= '0;
               i_ff    <= XW'(1);
            end
            S_FIT_MUL: begin
               xi_ff <= rx;
               vi_ff <= rv;
            end
            S_FIT_CMP: begin
               // earliest entry keeps a tie
               if (better) begin
                  best_ff <= i_ff;
                  bx_ff   <= xi_ff;
                  bv_ff   <= vi_ff;
               end
               i_ff <= i_ff + XW'(1);
            end
            S_FIT_END: begin
               lx0_ff[fit_h_ff]   <= bx_ff;
               lv0_ff[fit_h_ff]   <= bv_ff;
               lx1_ff[fit_h_ff]   <= pts_ff;
               lv1_ff[fit_h_ff]   <= fw;
               start_ff[fit_h_ff] <= start_ff[fit_h_ff] + best_ff;
               count_ff[fit_h_ff] <= count_ff[fit_h_ff] - best_ff;
               fit_h_ff           <= 1'b1;
            end
            S_PUSH: begin
               if (ram_we[0]) count_ff[0] <= count_ff[0] + XW'(1);
               if (ram_we[1]) count_ff[1] <= count_ff[1] + XW'(1);
               pts_ff <= pts_ff + XW'(1);
            end
            S_FLUSHCHK: begin
               brk_ff <= 1'b0;
            end
            S_EM_BEGIN: begin
               em_k_ff <= 2'd0;
               ssum_ff <= '0;
               isum_ff <= '0;
            end
            S_EM_WAIT: begin
               if (div_done) begin
                  if (em_k_ff[0]) begin
                     isum_ff <= isum_ff + SUMW'(div_quo);
                  end else begin
                     ssum_ff <= ssum_ff + SUMW'(div_quo);
                  end
                  em_k_ff <= em_k_ff + 2'd1;
               end
            end
            S_EM_OUT: begin
               // drop the flushed segment once it is handed over
               if (out_free && !brk_ff) begin
                  pts_ff      <= '0;
                  pivot_ff    <= '0;
                  start_ff[0] <= '0;
                  start_ff[1] <= '0;
                  count_ff[0] <= '0;
                  count_ff[1] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_EM_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
         rsp_len_ff   <= len_ext[LEN_W-1:0];
         rsp_last_ff  <= brk_ff ? !flush_ff : 1'b1;
         if (pts_ff < XW'(2)) begin
            rsp_slope_ff <= '0;
            rsp_icpt_ff  <= pivot_ff;
         end else begin
            rsp_slope_ff <= sat_s;
            rsp_icpt_ff  <= sat_i;
         end
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_if.ready             = (state_ff == S_IDLE);
   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.segment_length    = rsp_len_ff;
   assign rsp_if.segment_slope     = rsp_slope_ff;
   assign rsp_if.segment_intercept = rsp_icpt_ff;
   assign rsp_if.last_in_run       = rsp_last_ff;
endmodule

@@ rtl/opla_chk.sv @@
// Port-level checker for the PLA segmenter, bound to the top level.
// Depends on opla_pkg and optimal_pla_segmenter_core.
`timescale 1ns / 1ps
module opla_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [opla_pkg::LEN_W-1:0]         rsp_segment_length,
   input logic [opla_pkg::SAMPLE_W-1:0]      rsp_segment_slope,
   input logic [opla_pkg::SAMPLE_W-1:0]      rsp_segment_intercept,
   input logic                               rsp_last_in_run
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_segment_length) && $stable(rsp_segment_slope)
         && $stable(rsp_segment_intercept) && $stable(rsp_last_in_run))
      else $error("response payload changed while stalled");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segment_length != '0)
      else $error("empty segment emitted");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");
endmodule

bind optimal_pla_segmenter_core opla_chk u_opla_chk (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_if.valid),
   .req_ready             (req_if.ready),
   .rsp_valid             (rsp_if.valid),
   .rsp_ready             (rsp_if.ready),
   .rsp_segment_length    (rsp_if.segment_length),
   .rsp_segment_slope     (rsp_if.segment_slope),
   .rsp_segment_intercept (rsp_if.segment_intercept),
   .rsp_last_in_run       (rsp_if.last_in_run)
);

@@ test/optimal_pla_segmenter_core_test.sv @@
// Testbench for optimal_pla_segmenter_core: a directed table, then random sample runs
// under several register settings, checked against typed segments or an in-bench segment predictor.
// Depends on opla_pkg, opla_if and the segmenter RTL.
`timescale 1ns / 1ps
module optimal_pla_segmenter_core_test;
   import opla_pkg::*;

   localparam int      DEPTH    = DEF_HULL_DEPTH;
   localparam longint  VAL_MAX  = (64'sd1 <<< (DEF_VALUE_BITS - 1)) - 1;
   localparam longint  VAL_MIN  = -(64'sd1 <<< (DEF_VALUE_BITS - 1));
   localparam int      SETTLE   = 1000;
   localparam int      PHASE_ITEMS = 200;

   typedef struct {
      logic [LEN_W-1:0]           len;
      logic signed [SAMPLE_W-1:0] slope;
      logic signed [SAMPLE_W-1:0] icpt;
      logic                       last;
   } segment_t;

   typedef struct {
      longint x0;
      longint v0;
      longint x1;
      longint v1;
   } bound_t;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      bit                  eos;
      int                  n_typed;   // -1: use the predictor
      segment_t            seg0;
      segment_t            seg1;
   } dir_row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   opla_req_if req_if();
   opla_rsp_if rsp_if();

   optimal_pla_segmenter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // predictor state; index 1 is the upper hull / upper bound line, 0 the lower
   longint      hull_x [2][DEPTH];
   longint      hull_v [2][DEPTH];
   int unsigned hull_start [2];
   int unsigned hull_count [2];
   bound_t      bound [2];
   longint      pivot;
   int unsigned seg_points;
   longint      err_bound;
   int unsigned max_len;

   segment_t    pending_segments [$];
   int          mismatches = 0;
   bit          idle_on = 1;
   bit          pressure_req = 0;

   // random run generator state
   int          run_left = 0;
   longint      run_k, run_base, run_step;
   bit          run_noisy;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic longint sat_val(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint floor_div(longint n, longint d);
      longint q;
      if (d <= 0) return 0;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic int side_of(bound_t l, longint x, longint w);
      longint lhs, rhs;
      lhs = (l.v1 - l.v0) * (x - l.x0);
      rhs = (w - l.v0) * (l.x1 - l.x0);
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic void hull_add(int h, longint x, longint v);
      int unsigned pos;
      pos = hull_start[h] + hull_count[h];
      if (pos < DEPTH) begin
         hull_x[h][pos] = x;
         hull_v[h][pos] = v;
         hull_count[h]++;
      end
   endfunction

   // tighten bound h from the best hull entry to (x, w); drop entries before it
   function automatic void hull_fit(int h, longint x, longint w, bit want_min);
      int unsigned best, i, pi, pb;
      longint a, b;
      if (hull_count[h] == 0) return;
      best = 0;
      for (i = 1; i < hull_count[h]; i++) begin
         pi = hull_start[h] + i;
         pb = hull_start[h] + best;
         if (pi >= DEPTH || pb >= DEPTH) break;
         a = (w - hull_v[h][pi]) * (x - hull_x[h][pb]);
         b = (w - hull_v[h][pb]) * (x - hull_x[h][pi]);
         if (want_min ? (a < b) : (a > b)) best = i;
      end
      if (hull_start[h] + best < DEPTH)
         bound[h] = '{hull_x[h][hull_start[h] + best], hull_v[h][hull_start[h] + best], x, w};
      hull_start[h] += best;
      hull_count[h] -= best;
   endfunction

   function automatic longint bound_slope(bound_t l);
      return floor_div(l.v1 - l.v0, l.x1 - l.x0);
   endfunction

   function automatic longint bound_icpt(bound_t l);
      longint dx;
      dx = l.x1 - l.x0;
      return floor_div(l.v0 * dx - (l.v1 - l.v0) * l.x0, dx);
   endfunction

   function automatic segment_t open_segment();
      segment_t r;
      longint s, c;
      if (seg_points >= 2) begin
         s = floor_div(bound_slope(bound[1]) + bound_slope(bound[0]), 2);
         c = floor_div(bound_icpt(bound[1]) + bound_icpt(bound[0]), 2);
      end else begin
         s = 0;
         c = pivot;
      end
      r.len   = seg_points[LEN_W-1:0];
      r.slope = sat32(s);
      r.icpt  = sat32(c);
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic void clear_segment();
      for (int h = 0; h < 2; h++) begin
         hull_start[h] = 0;
         hull_count[h] = 0;
         bound[h] = '{0, 0, 0, 0};
      end
      pivot = 0;
      seg_points = 0;
   endfunction

   function automatic void start_segment(longint y, longint wl, longint wu);
      clear_segment();
      pivot = y;
      hull_add(1, 0, wl);
      hull_add(0, 0, wu);
      seg_points = 1;
   endfunction

   // advance the segment state by one sample; return the segments it closes
   function automatic int segment_step(logic [31:0] raw, bit eos, output segment_t outs[2]);
      longint y, wu, wl, x;
      int unsigned m;
      int n;
      bit move_u, move_l;
      y  = longint'($signed(raw));
      wu = sat_val(y + err_bound);
      wl = sat_val(y - err_bound);
      x  = seg_points;
      m  = max_len;
      n  = 0;
      if (m < MIN_SEG_LEN) m = MIN_SEG_LEN;
      if (m > DEPTH) m = DEPTH;
      if (seg_points == 0) begin
         start_segment(y, wl, wu);
      end else if (seg_points == 1) begin
         bound[1] = '{hull_x[1][hull_start[1] % DEPTH], hull_v[1][hull_start[1] % DEPTH], x, wu};
         bound[0] = '{hull_x[0][hull_start[0] % DEPTH], hull_v[0][hull_start[0] % DEPTH], x, wl};
         hull_add(1, x, wl);
         hull_add(0, x, wu);
         seg_points = 2;
      end else if (side_of(bound[0], x, wu) > 0 || side_of(bound[1], x, wl) < 0 ||
                   seg_points >= m) begin
         outs[n] = open_segment();
         n++;
         start_segment(y, wl, wu);
      end else begin
         move_u = side_of(bound[1], x, wu) > 0;
         move_l = side_of(bound[0], x, wl) < 0;
         if (move_u) hull_fit(1, x, wu, 1'b1);
         if (move_l) hull_fit(0, x, wl, 1'b0);
         if (move_u) hull_add(0, x, wu);
         if (move_l) hull_add(1, x, wl);
         seg_points++;
      end
      if (eos) begin
         outs[n] = open_segment();
         n++;
         clear_segment();
      end
      if (n > 0) outs[n-1].last = 1'b1;
      return n;
   endfunction

   // offer one request; n_typed < 0 queues the predicted segments, else the typed ones
   task automatic send_request(logic [31:0] sample, bit eos, int n_typed,
                               segment_t t0, segment_t t1);
      segment_t outs[2];
      int n;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.sample_value  <= sample;
      req_if.end_of_stream <= eos;
      do @(posedge clock); while (!req_if.ready);
      n = segment_step(sample, eos, outs);
      if (n_typed < 0) begin
         for (int i = 0; i < n; i++) pending_segments.push_back(outs[i]);
      end else begin
         if (n_typed > 0) pending_segments.push_back(t0);
         if (n_typed > 1) pending_segments.push_back(t1);
      end
   endtask

   task automatic drain();
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_config(logic [30:0] eb, logic [13:0] ml);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_ERROR_BOUND;
      csr_wdata <= eb;
      @(posedge clock);
      csr_addr  <= CSR_MAX_LEN;
      csr_wdata <= {17'd0, ml};
      @(posedge clock);
      csr_we    <= 1'b0;
      err_bound = longint'(eb);
      max_len   = ml;
   endtask

   // mostly straight runs within the band, some pure noise
   task automatic next_sample(output logic [31:0] s, output bit eos);
      longint v;
      if (run_left == 0) begin
         run_left  = $urandom_range(2, 40);
         run_k     = 0;
         run_noisy = ($urandom_range(0, 4) == 0);
         run_base  = longint'($signed($urandom)) >>> $urandom_range(0, 16);
         run_step  = longint'($signed($urandom)) >>> $urandom_range(8, 28);
      end
      if (run_noisy) begin
         v = longint'($signed($urandom));
      end else begin
         v = run_base + run_step * run_k;
         if (err_bound > 0)
            v += longint'($urandom_range(0, int'(err_bound))) - err_bound / 2;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      s   = v[31:0];
      eos = (run_left == 1 && $urandom_range(0, 3) == 0) || $urandom_range(0, 40) == 0;
      run_left--;
      run_k++;
   endtask

   // response side: check, then pick ready for the next cycle
   initial begin
      int hold;
      segment_t want;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_segments.size() == 0) begin
               $display("%0t: unexpected segment len=%0d slope=%0d icpt=%0d last=%0b", $time,
                        rsp_if.segment_length, rsp_if.segment_slope,
                        rsp_if.segment_intercept, rsp_if.last_in_run);
               mismatches++;
            end else begin
               want = pending_segments.pop_front();
               if (rsp_if.segment_length !== want.len) begin
                  $display("%0t: segment_length expected %0d actual %0d", $time,
                           want.len, rsp_if.segment_length);
                  mismatches++;
               end
               if (rsp_if.segment_slope !== want.slope) begin
                  $display("%0t: segment_slope expected %0d actual %0d", $time,
                           want.slope, rsp_if.segment_slope);
                  mismatches++;
               end
               if (rsp_if.segment_intercept !== want.icpt) begin
                  $display("%0t: segment_intercept expected %0d actual %0d", $time,
                           want.icpt, rsp_if.segment_intercept);
                  mismatches++;
               end
               if (rsp_if.last_in_run !== want.last) begin
                  $display("%0t: last_in_run expected %0b actual %0b", $time,
                           want.last, rsp_if.last_in_run);
                  mismatches++;
               end
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else if (pressure_req) begin
            pressure_req = 0;
            hold = 3000;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            hold = $urandom_range(1, 17) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      dir_row_t    rows [$];
      dir_row_t    r;
      segment_t    none;
      logic [30:0] phase_eb [6];
      logic [13:0] phase_ml [6];
      logic [31:0] s;
      bit          eos;

      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_addr             <= CSR_ERROR_BOUND;
      csr_wdata            <= '0;
      req_if.valid         <= 1'b0;
      req_if.sample_value  <= '0;
      req_if.end_of_stream <= 1'b0;
      for (int h = 0; h < 2; h++)
         for (int i = 0; i < DEPTH; i++) begin
            hull_x[h][i] = 0;
            hull_v[h][i] = 0;
         end
      clear_segment();
      err_bound = longint'(ERR_BOUND_RESET);
      max_len   = MAX_LEN_RESET;
      none = '{14'd0, 32'sd0, 32'sd0, 1'b0};

      // lone samples at both extremes, a flat pair, then break and flush together
      rows.push_back('{32'h7fff_ffff, 1, 1, '{14'd1, 32'sd0, 32'sh7fff_ffff, 1'b1}, none});
      rows.push_back('{32'h8000_0000, 1, 1, '{14'd1, 32'sd0, 32'sh8000_0000, 1'b1}, none});
      rows.push_back('{32'h0000_0000, 0, 0, none, none});
      rows.push_back('{32'h0000_0000, 1, 1, '{14'd2, 32'sd0, 32'sd0, 1'b1}, none});
      rows.push_back('{32'h0000_0000, 0, 0, none, none});
      rows.push_back('{32'h0000_0000, 0, 0, none, none});
      rows.push_back('{32'h000a_0000, 1, 2, '{14'd2, 32'sd0, 32'sd0, 1'b0},
                                             '{14'd1, 32'sd0, 32'sh000a_0000, 1'b1}});
      for (int k = 0; k < 6; k++)
         rows.push_back('{32'h0001_0000 * k, (k == 5), -1, none, none});
      rows.push_back('{32'h7fff_ffff, 0, -1, none, none});
      rows.push_back('{32'h7fff_ffff, 0, -1, none, none});
      rows.push_back('{32'h8000_0000, 1, -1, none, none});
      for (int k = 0; k < 3; k++)
         rows.push_back('{32'h8000_0000, (k == 2), -1, none, none});
      rows.push_back('{32'h1234_5678, 0, -1, none, none});
      rows.push_back('{32'hedcb_a988, 0, -1, none, none});
      rows.push_back('{32'h5555_5555, 1, -1, none, none});
      // flat run, flushed on its last sample
      for (int k = 0; k < 5; k++)
         rows.push_back('{32'h0003_0000, (k == 4), -1, none, none});

      phase_eb = '{31'd0,         31'h7fff_ffff, 31'd1000, 31'd300000, 31'd65536, 31'd40};
      phase_ml = '{14'd2,         14'd8192,      14'd16383, 14'd1,     14'd7,     14'd0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         r = rows[i];
         send_request(r.sample, r.eos, r.n_typed, r.seg0, r.seg1);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         next_sample(s, eos);
         send_request(s, eos, -1, none, none);
      end
      req_if.valid <= 1'b0;

      for (int p = 0; p < 6; p++) begin
         write_config(phase_eb[p], phase_ml[p]);
         // hold off the response side while requests keep coming
         if (p == 0) pressure_req = 1;
         if (p == 5) idle_on = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            next_sample(s, eos);
            send_request(s, eos, -1, none, none);
         end
         req_if.valid <= 1'b0;
      end

      drain();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
